>>> src/pqr_pkg.sv
package pqr_pkg;

   localparam int TASK_W = 8;
   localparam int PRIO_W = 8;
   localparam int OCC_W  = 5;

   typedef enum logic [1:0] {
      KIND_SORTED = 2'd0,
      KIND_FRONT  = 2'd1,
      KIND_POP    = 2'd2,
      KIND_REMOVE = 2'd3
   } pqr_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_NOTFOUND = 2'd3
   } pqr_status_type;

   typedef struct packed {
      pqr_kind_type        kind;
      logic [TASK_W-1:0]   task_id;
      logic [PRIO_W-1:0]   priority_req;
   } pqr_req_type;

   typedef struct packed {
      logic [TASK_W-1:0]   out_task;
      logic                out_valid;
      pqr_status_type      status;
      logic [OCC_W-1:0]    occupancy;
   } pqr_rsp_type;

   typedef struct packed {
      pqr_kind_type kind;
      logic         commit;
   } pqr_ctrl_type;

endpackage

>>> src/pqr_chan_if.sv
interface pqr_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> src/pqr_cell.sv
module pqr_cell #(
   parameter int ID_BITS   = 8,
   parameter int PRIO_BITS = 8
) (
   input  logic                  clock,
   input  pqr_pkg::pqr_ctrl_type ctrl,
   input  logic [ID_BITS-1:0]    new_id,
   input  logic [PRIO_BITS-1:0]  new_prio,
   input  logic                  slot_valid,
   input  logic                  slot_tail,
   input  logic [ID_BITS-1:0]    left_id,
   input  logic [PRIO_BITS-1:0]  left_prio,
   input  logic [ID_BITS-1:0]    right_id,
   input  logic [PRIO_BITS-1:0]  right_prio,
   input  logic                  chain_in,
   output logic                  chain_out,
   output logic [ID_BITS-1:0]    id_q,
   output logic [PRIO_BITS-1:0]  prio_q
);
   import pqr_pkg::*;

   logic [ID_BITS-1:0]   task_ff, task_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic                 hit;
   logic                 is_insert;

   always_comb begin
      case (ctrl.kind)
         KIND_SORTED: hit = (slot_valid && (prio_ff > new_prio)) || slot_tail;
         KIND_FRONT:  hit = 1'b1;
         KIND_POP:    hit = 1'b1;
         KIND_REMOVE: hit = slot_valid && (task_ff == new_id);
         default:     hit = 1'b0;
      endcase
   end

   assign chain_out = chain_in || hit;
   assign is_insert = (ctrl.kind == KIND_SORTED) || (ctrl.kind == KIND_FRONT);

   always_comb begin
      task_in = task_ff;
      prio_in = prio_ff;
      if (ctrl.commit && chain_out) begin
         if (is_insert) begin
            task_in = chain_in ? left_id : new_id;
            prio_in = chain_in ? left_prio : new_prio;
         end else begin
            task_in = right_id;
            prio_in = right_prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      task_ff <= task_in;
      prio_ff <= prio_in;
   end

   assign id_q   = task_ff;
   assign prio_q = prio_ff;

endmodule

>>> src/priority_ready_queue_top.sv
// Flow: a taken request is registered and the FSM moves to S_EXEC; there the
// response is registered once the response side is free. No new request is
// taken before S_IDLE; the decision and the cell chain shift are combinational.
// Reset: synchronous, active high; clears occupancy and handshake state only.
// Cell contents are left as they are and are not used as entries until written.
module priority_ready_queue_top #(
   parameter int DEPTH     = 16,
   parameter int PRIO_BITS = 8,
   parameter int ID_BITS   = 8
) (
   input logic       clock,
   input logic       reset,
   pqr_chan_if.sink   req_chan,
   pqr_chan_if.source rsp_chan
);
   import pqr_pkg::*;

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type            state_ff, state_in;
   pqr_req_type          op_ff, op_in;
   pqr_rsp_type          rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   logic [CNT_BITS-1:0]  count_next;
   pqr_status_type       status;
   logic                 commit;
   logic                 exec_go;
   logic                 full;
   logic                 empty;
   logic                 found;
   pqr_ctrl_type         ctrl;
   logic [ID_BITS-1:0]   new_id;
   logic [PRIO_BITS-1:0] new_prio;

   logic [ID_BITS-1:0]   cell_task [DEPTH];
   logic [PRIO_BITS-1:0] cell_prio [DEPTH];
   logic [DEPTH:0]       chain;

   assign new_id   = ID_BITS'(op_ff.task_id);
   assign new_prio = PRIO_BITS'(op_ff.priority_req);
   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign found    = chain[DEPTH];
   assign exec_go  = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_chan.ready);
   assign ctrl.kind   = op_ff.kind;
   assign ctrl.commit = commit;
   assign chain[0]    = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ID_BITS-1:0]   left_id, right_id;
      logic [PRIO_BITS-1:0] left_prio, right_prio;
      logic                 slot_valid, slot_tail;

      assign slot_valid = (CNT_BITS'(i) < count_ff);
      assign slot_tail  = (CNT_BITS'(i) == count_ff);

      if (i == 0) begin : g_head
         assign left_id   = new_id;
         assign left_prio = new_prio;
      end else begin : g_body
         assign left_id   = cell_task[i-1];
         assign left_prio = cell_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_id   = cell_task[i];
         assign right_prio = cell_prio[i];
      end else begin : g_next
         assign right_id   = cell_task[i+1];
         assign right_prio = cell_prio[i+1];
      end

      pqr_cell #(
         .ID_BITS   (ID_BITS),
         .PRIO_BITS (PRIO_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .new_id     (new_id),
         .new_prio   (new_prio),
         .slot_valid (slot_valid),
         .slot_tail  (slot_tail),
         .left_id    (left_id),
         .left_prio  (left_prio),
         .right_id   (right_id),
         .right_prio (right_prio),
         .chain_in   (chain[i]),
         .chain_out  (chain[i+1]),
         .id_q       (cell_task[i]),
         .prio_q     (cell_prio[i])
      );
   end

   always_comb begin
      commit     = 1'b0;
      status     = STATUS_OK;
      count_next = count_ff;
      case (op_ff.kind)
         KIND_SORTED, KIND_FRONT: begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               commit     = exec_go;
               count_next = count_ff + 1'b1;
            end
         end
         KIND_POP: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               commit     = exec_go;
               count_next = count_ff - 1'b1;
            end
         end
         KIND_REMOVE: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else if (!found) begin
               status = STATUS_NOTFOUND;
            end else begin
               commit     = exec_go;
               count_next = count_ff - 1'b1;
            end
         end
         default: begin
            status = STATUS_OK;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      count_in     = count_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in    = req_chan.payload;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               rsp_valid_in     = 1'b1;
               rsp_in.out_valid = (op_ff.kind == KIND_POP) && !empty;
               rsp_in.out_task  = ((op_ff.kind == KIND_POP) && !empty) ?
                                  TASK_W'(cell_task[0]) : '0;
               rsp_in.status    = status;
               rsp_in.occupancy = OCC_W'(count_next);
               count_in         = count_next;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      op_ff  <= op_in;
      rsp_ff <= rsp_in;
   end

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("occupancy beyond depth");

   a_exec_responds: assert property (@(posedge clock) disable iff (reset)
      exec_go |=> rsp_valid_ff)
      else $error("executed transaction gave no response");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      exec_go && full && (op_ff.kind == KIND_SORTED || op_ff.kind == KIND_FRONT)
      |=> $stable(count_ff))
      else $error("insert into full queue changed occupancy");

   a_pop_decrements: assert property (@(posedge clock) disable iff (reset)
      exec_go && !empty && op_ff.kind == KIND_POP
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("pop did not decrement occupancy");

   a_remove_found: assert property (@(posedge clock) disable iff (reset)
      commit && op_ff.kind == KIND_REMOVE |-> found && !empty)
      else $error("remove committed without a match");
`endif

endmodule
